/* hw/rtl/ccl_pkg.sv */
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared constants, codes and control types of the compact byte list table.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned POSITION_W = 4;
  localparam int unsigned REMOVED_W  = 5;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned EXT_W      = 8;

  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_APP_UNQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_IDX   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_ALL   = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd4;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

/* hw/rtl/ccl_in_if.sv */
// ----------------------------------------------------------------------------
// ccl_in_if
// Operation channel: one word names an operation with its value and index.
// ----------------------------------------------------------------------------
interface ccl_in_if;
  logic                          valid;
  logic                          ready;
  logic [ccl_pkg::OP_W-1:0]      operation;
  logic [ccl_pkg::VAL_W-1:0]     value;
  logic [ccl_pkg::IDX_W-1:0]     index;

  modport source (output valid, operation, value, index, input ready);
  modport sink   (input valid, operation, value, index, output ready);
endinterface

/* hw/rtl/ccl_out_if.sv */
// ----------------------------------------------------------------------------
// ccl_out_if
// Result channel: one word per operation with status, position and counts.
// ----------------------------------------------------------------------------
interface ccl_out_if;
  logic                           valid;
  logic                           ready;
  logic [ccl_pkg::STATUS_W-1:0]   status;
  logic [ccl_pkg::POSITION_W-1:0] position;
  logic [ccl_pkg::REMOVED_W-1:0]  removed;
  logic [ccl_pkg::FILL_W-1:0]     fill;

  modport source (output valid, status, position, removed, fill, input ready);
  modport sink   (input valid, status, position, removed, fill, output ready);
endinterface

/* hw/rtl/compact_char_list_table.sv */
// ----------------------------------------------------------------------------
// compact_char_list_table
// Compact list of byte entries with append, unique append, deletes and search.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   operation, value, index
//   out_o    out  valid/ready   status, position, removed, fill
//
// on a nonempty list a scanning word reads every entry before its result is committed
// and the next word can be taken once the controller is back in idle after that commit
// the scan reads one entry per cycle through the single memory read port
// words with no pass (append, unused codes, empty list, bad index) read no entry
// reset clears the fill count; entries need no clearing
// a finished result waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
module compact_char_list_table #(
  parameter int unsigned CAPACITY = ccl_pkg::CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ccl_in_if.sink    in_i,
  ccl_out_if.source out_o
);
  import ccl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ccl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (in_i.operation),
    .value_i     (in_i.value),
    .index_i     (in_i.index),
    .status_o    (out_o.status),
    .position_o  (out_o.position),
    .removed_o   (out_o.removed),
    .fill_o      (out_o.fill)
  );

endmodule

/* hw/rtl/ccl_dp.sv */
// ----------------------------------------------------------------------------
// ccl_dp
// Datapath: entry memory, scan pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module ccl_dp #(
  parameter int unsigned CAPACITY = ccl_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ccl_pkg::cmd_t                  cmd_i,
  output ccl_pkg::sts_t                  sts_o,
  input  logic [ccl_pkg::OP_W-1:0]       operation_i,
  input  logic [ccl_pkg::VAL_W-1:0]      value_i,
  input  logic [ccl_pkg::IDX_W-1:0]      index_i,
  output logic [ccl_pkg::STATUS_W-1:0]   status_o,
  output logic [ccl_pkg::POSITION_W-1:0] position_o,
  output logic [ccl_pkg::REMOVED_W-1:0]  removed_o,
  output logic [ccl_pkg::FILL_W-1:0]     fill_o
);
  import ccl_pkg::*;

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]     op_q;
  logic [VAL_W-1:0]    val_q;
  logic [IDX_W-1:0]    idx_q;
  logic [FW-1:0]       fill_q;
  logic [FW-1:0]       rd_q;
  logic [FW-1:0]       wr_q;
  logic                pend_q;
  logic                hit_q;
  logic [IW-1:0]       rpos_q;
  logic [IW-1:0]       pos_q;
  logic [VAL_W-1:0]    rdata_q;
  logic [STATUS_W-1:0] status_q;
  logic [EXT_W-1:0]    pos_ext_q;
  logic [EXT_W-1:0]    removed_ext_q;
  logic [EXT_W-1:0]    fill_ext_q;

  logic                fill_zero_c;
  logic                full_c;
  logic                bad_idx_c;
  logic                is_del_c;
  logic                need_scan_c;
  logic                issue_c;
  logic                proc_c;
  logic                match_c;
  logic                skip_c;
  logic                app_c;
  logic [STATUS_W-1:0] status_c;
  logic [IW-1:0]       pos_c;
  logic [FW-1:0]       removed_c;
  logic [FW-1:0]       fill_c;
  logic                we_c;
  logic [IW-1:0]       waddr_c;
  logic [VAL_W-1:0]    wdata_c;

  always_comb begin
    fill_zero_c = (fill_q == '0);
    full_c      = (fill_q == FW'(CAPACITY));
    bad_idx_c   = (EXT_W'(idx_q) >= EXT_W'(fill_q));
    is_del_c    = (op_q == OP_DEL_FIRST) || (op_q == OP_DEL_IDX) || (op_q == OP_DEL_ALL);
    need_scan_c = (op_q == OP_APP_UNQ) ||
                  ((is_del_c || (op_q == OP_SEARCH)) && !fill_zero_c &&
                   !((op_q == OP_DEL_IDX) && bad_idx_c));
    issue_c     = cmd_i.scan && need_scan_c && (rd_q != fill_q);
    proc_c      = cmd_i.scan && pend_q;
    match_c     = (rdata_q == val_q);
    skip_c      = ((op_q == OP_DEL_FIRST) && match_c && !hit_q) ||
                  ((op_q == OP_DEL_IDX) && (EXT_W'(rpos_q) == EXT_W'(idx_q))) ||
                  ((op_q == OP_DEL_ALL) && match_c);
    sts_o.scan_done = !pend_q && (!need_scan_c || (rd_q == fill_q));
  end

  // result of the finished pass
  always_comb begin
    status_c  = ST_OK;
    pos_c     = '0;
    removed_c = '0;
    fill_c    = fill_q;
    app_c     = 1'b0;
    case (op_q)
      OP_APPEND: begin
        if (full_c) status_c = ST_FULL;
        else        app_c    = 1'b1;
      end
      OP_APP_UNQ: begin
        if (hit_q)       status_c = ST_MISS;
        else if (full_c) status_c = ST_FULL;
        else             app_c    = 1'b1;
      end
      OP_DEL_FIRST, OP_DEL_IDX, OP_DEL_ALL: begin
        if (fill_zero_c) begin
          status_c = ST_EMPTY;
        end else if ((op_q == OP_DEL_IDX) && bad_idx_c) begin
          status_c = ST_BADIDX;
        end else begin
          removed_c = fill_q - wr_q;
          fill_c    = wr_q;
          if (removed_c == '0) status_c = ST_MISS;
        end
      end
      OP_SEARCH: begin
        if (fill_zero_c) status_c = ST_EMPTY;
        else if (hit_q)  pos_c    = pos_q;
        else             status_c = ST_MISS;
      end
      default: ;
    endcase
    if (app_c) fill_c = fill_q + FW'(1);
  end

  always_comb begin
    we_c    = (proc_c && is_del_c && !skip_c) || (cmd_i.commit && app_c);
    waddr_c = cmd_i.commit ? fill_q[IW-1:0] : wr_q[IW-1:0];
    wdata_c = cmd_i.commit ? val_q : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (we_c) mem[waddr_c] <= wdata_c;
    if (issue_c) begin
      rdata_q <= mem[rd_q[IW-1:0]];
      rpos_q  <= rd_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (cmd_i.load) begin
      rd_q   <= '0;
      wr_q   <= '0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      pend_q <= issue_c;
      if (issue_c) rd_q <= rd_q + FW'(1);
      if (proc_c && is_del_c && !skip_c) wr_q <= wr_q + FW'(1);
      if (proc_c && match_c) hit_q <= 1'b1;
      if (cmd_i.commit) fill_q <= fill_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      val_q <= value_i;
      idx_q <= index_i;
    end
    if (proc_c && match_c && !hit_q) pos_q <= rpos_q;
    if (cmd_i.commit) begin
      status_q      <= status_c;
      pos_ext_q     <= EXT_W'(pos_c);
      removed_ext_q <= EXT_W'(removed_c);
      fill_ext_q    <= EXT_W'(fill_c);
    end
  end

  assign status_o   = status_q;
  assign position_o = pos_ext_q[POSITION_W-1:0];
  assign removed_o  = removed_ext_q[REMOVED_W-1:0];
  assign fill_o     = fill_ext_q[FILL_W-1:0];

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(CAPACITY))
    else $error("fill count above capacity");

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q)
    else $error("write pointer ahead of read pointer");

  a_del_first_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (op_q == OP_DEL_FIRST) |-> (fill_q - wr_q) <= FW'(1))
    else $error("delete first removed more than one entry");

endmodule

/* hw/rtl/ccl_ctrl.sv */
// ----------------------------------------------------------------------------
// ccl_ctrl
// Controller: sequences load, scan pass and commit for one word at a time.
// ----------------------------------------------------------------------------
module ccl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ccl_pkg::cmd_t cmd_o,
  input  ccl_pkg::sts_t sts_i
);
  import ccl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy_c;

  always_comb begin
    out_busy_c  = out_valid_q && !out_ready_i;
    in_ready_o  = (state_q == S_IDLE);
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_busy_c;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_busy_c) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN && out_valid_q == $past(out_busy_c))
    else $error("load not followed by scan");

endmodule

/* test/compact_char_list_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_char_list_table_test
// Self-checking bench for the compact byte list table. Operation words are
// offered over the input channel, and each accepted word is applied to a
// behavioral copy of the list to predict its result word. The results that
// come back are compared field by field, in order. Directed cases cover the
// empty list, the full list, duplicates, bad indexes, removal of every match
// and the unused codes. Random traffic then walks the list between empty and
// full under four idle and stall mixes, and finally the result side is held
// off long enough to back up the input.
// ----------------------------------------------------------------------------
module compact_char_list_table_test;
  import ccl_pkg::*;

  localparam int unsigned LIST_DEPTH     = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS    = 50;

  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [POSITION_W-1:0] position;
    logic [REMOVED_W-1:0]  removed;
    logic [FILL_W-1:0]     fill;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic rx_hold;
  logic hold_request;

  ccl_in_if  op_ch ();
  ccl_out_if res_ch ();

  compact_char_list_table #(
    .CAPACITY(LIST_DEPTH)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (op_ch),
    .out_o (res_ch)
  );

  logic [VAL_W-1:0] list_bytes [LIST_DEPTH];
  int               list_fill;
  outcome_t         expected_outcomes [$];
  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < list_fill; i++) begin
      list_bytes[i] = list_bytes[i + 1];
    end
    list_fill--;
  endfunction

  function automatic outcome_t list_apply(input logic [OP_W-1:0] op,
                                          input logic [VAL_W-1:0] val,
                                          input logic [IDX_W-1:0] idx);
    outcome_t o;
    int       hit_pos;
    int       kept;
    o       = '0;
    hit_pos = -1;
    kept    = 0;
    for (int i = list_fill - 1; i >= 0; i--) begin
      if (list_bytes[i] == val) hit_pos = i;
    end
    case (op)
      OP_APPEND, OP_APP_UNQ: begin
        if (op == OP_APP_UNQ && hit_pos >= 0) begin
          o.status = ST_MISS;
        end else if (list_fill >= LIST_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          list_bytes[list_fill] = val;
          list_fill++;
        end
      end
      OP_DEL_FIRST: begin
        if (list_fill == 0) begin
          o.status = ST_EMPTY;
        end else if (hit_pos < 0) begin
          o.status = ST_MISS;
        end else begin
          drop_entry(hit_pos);
          o.removed = REMOVED_W'(1);
        end
      end
      OP_DEL_IDX: begin
        if (list_fill == 0) begin
          o.status = ST_EMPTY;
        end else if (int'(idx) >= list_fill) begin
          o.status = ST_BADIDX;
        end else begin
          drop_entry(int'(idx));
          o.removed = REMOVED_W'(1);
        end
      end
      OP_DEL_ALL: begin
        if (list_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_fill; i++) begin
            if (list_bytes[i] != val) begin
              list_bytes[kept] = list_bytes[i];
              kept++;
            end
          end
          o.removed = REMOVED_W'(list_fill - kept);
          list_fill = kept;
          if (o.removed == 0) o.status = ST_MISS;
        end
      end
      OP_SEARCH: begin
        if (list_fill == 0) begin
          o.status = ST_EMPTY;
        end else if (hit_pos < 0) begin
          o.status = ST_MISS;
        end else begin
          o.position = POSITION_W'(hit_pos);
        end
      end
      default: begin
      end
    endcase
    o.fill = FILL_W'(list_fill);
    return o;
  endfunction

  task automatic offer_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                          input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.operation <= op;
    op_ch.value     <= val;
    op_ch.index     <= idx;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    expected_outcomes.push_back(list_apply(op, val, idx));
  endtask

  // result side: random stalls, plus the long hold-off when requested
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rx_hold      = 1'b0;
    hold_request = 1'b0;
    forever begin
      wait (hold_request);
      hold_request = 1'b0;
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result word with no operation outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res_ch.status, want.status));
        if (res_ch.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", res_ch.position,
                                    want.position));
        if (res_ch.removed !== want.removed)
          report_mismatch($sformatf("removed %0d, want %0d", res_ch.removed, want.removed));
        if (res_ch.fill !== want.fill)
          report_mismatch($sformatf("fill %0d, want %0d", res_ch.fill, want.fill));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("compact_char_list_table_test NOT OK");
    $finish;
  end

  task automatic test_empty_list();
    offer_op(OP_DEL_FIRST, 8'h00, 4'd0);
    offer_op(OP_DEL_IDX, 8'hFF, 4'd15);
    offer_op(OP_DEL_ALL, 8'h20, 4'd0);
    offer_op(OP_SEARCH, 8'hFF, 4'd0);
  endtask

  task automatic test_fill_and_overflow();
    logic [VAL_W-1:0] fill_vals [LIST_DEPTH] = '{
      8'h00, 8'hFF, 8'h20, 8'h80, 8'h01, 8'h7F, 8'h20, 8'h55,
      8'hAA, 8'hFF, 8'h10, 8'h08, 8'h04, 8'h02, 8'h40, 8'hFF};
    for (int i = 0; i < LIST_DEPTH; i++) begin
      offer_op((i % 3 == 1) ? OP_APP_UNQ : OP_APPEND, fill_vals[i], IDX_W'(i));
    end
    offer_op(OP_APPEND, 8'h33, 4'd0);
    offer_op(OP_APP_UNQ, 8'h20, 4'd0);
    offer_op(OP_APP_UNQ, 8'h33, 4'd0);
  endtask

  task automatic test_deletes_and_search();
    // last entry matches too
    offer_op(OP_DEL_ALL, 8'hFF, 4'd0);
    offer_op(OP_DEL_IDX, 8'h00, IDX_W'(list_fill));
    offer_op(OP_DEL_FIRST, 8'h33, 4'd0);
    offer_op(OP_DEL_FIRST, 8'h20, 4'd0);
    offer_op(OP_SEARCH, 8'h20, 4'd0);
    offer_op(OP_RSVD_A, 8'hFF, 4'd15);
    offer_op(OP_RSVD_B, 8'h00, 4'd0);
  endtask

  task automatic test_random_ops(input int unsigned count, input int unsigned idle_pct,
                                 input int unsigned stall_pct);
    logic [VAL_W-1:0] pool [5];
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    int unsigned      r;
    int unsigned      pick;
    bit               grow;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    grow = 1'b1;
    foreach (pool[i]) pool[i] = VAL_W'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      if (list_fill >= LIST_DEPTH) grow = 1'b0;
      else if (list_fill == 0) grow = 1'b1;
      else if ($urandom_range(99) < 3) grow = !grow;
      r = $urandom_range(99);
      if (grow) begin
        if (r < 40) op = OP_APPEND;
        else if (r < 55) op = OP_APP_UNQ;
        else if (r < 62) op = OP_DEL_FIRST;
        else if (r < 67) op = OP_DEL_IDX;
        else if (r < 72) op = OP_DEL_ALL;
        else if (r < 96) op = OP_SEARCH;
        else if (r < 98) op = OP_RSVD_A;
        else op = OP_RSVD_B;
      end else begin
        if (r < 10) op = OP_APPEND;
        else if (r < 15) op = OP_APP_UNQ;
        else if (r < 40) op = OP_DEL_FIRST;
        else if (r < 62) op = OP_DEL_IDX;
        else if (r < 72) op = OP_DEL_ALL;
        else if (r < 96) op = OP_SEARCH;
        else if (r < 98) op = OP_RSVD_A;
        else op = OP_RSVD_B;
      end
      if (list_fill > 0 && op != OP_APPEND && $urandom_range(99) < 50)
        val = list_bytes[$urandom_range(list_fill - 1)];
      else if ($urandom_range(99) < 70)
        val = pool[$urandom_range(4)];
      else
        val = VAL_W'($urandom_range(255));
      if ($urandom_range(9) < 8) begin
        pick = $urandom_range(list_fill);
        if (pick > 15) pick = 15;
      end else begin
        pick = $urandom_range(15);
      end
      offer_op(op, val, IDX_W'(pick));
    end
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    test_random_ops(40, 0, 0);
  endtask

  initial begin
    rst_n           <= 1'b0;
    op_ch.valid     <= 1'b0;
    op_ch.operation <= OP_APPEND;
    op_ch.value     <= '0;
    op_ch.index     <= '0;
    list_fill       = 0;
    error_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_fill_and_overflow();
    test_deletes_and_search();
    test_random_ops(400, 0, 0);
    test_random_ops(400, 73, 0);
    test_random_ops(400, 0, 73);
    test_random_ops(400, 14, 14);
    test_backpressure();

    op_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("compact_char_list_table_test OK");
    end else begin
      $display("compact_char_list_table_test NOT OK");
    end
    $finish;
  end

endmodule
